/* hdl/c8eu_pkg.sv */
package c8eu_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_UNSUP     = 2'd3
  } status_e;

  localparam logic [11:0] PC_RESET   = 12'h200;
  localparam logic [11:0] FONT_RESET = 12'd80;

  // Opcode top nibbles
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEB  = 4'h3;
  localparam logic [3:0] OP_SNEB = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDB  = 4'h6;
  localparam logic [3:0] OP_ADDB = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [15:0] INS_RET = 16'h00EE;

  // ALU sub-ops
  localparam logic [3:0] ALU_LD  = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  // FX sub-ops
  localparam logic [7:0] FX_GDT = 8'h07;
  localparam logic [7:0] FX_SDT = 8'h15;
  localparam logic [7:0] FX_SST = 8'h18;
  localparam logic [7:0] FX_ADI = 8'h1E;
  localparam logic [7:0] FX_FNT = 8'h29;
  localparam logic [7:0] FX_BCD = 8'h33;
  localparam logic [7:0] FX_STR = 8'h55;
  localparam logic [7:0] FX_LDR = 8'h65;

endpackage

/* hdl/c8eu_ram.sv */
module c8eu_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/chip8_execute_unit_top.sv */
// CHIP-8 execute unit.
// Input stream: s_axis_tdata carries {random_byte, instruction}; one item is
// one instruction. Output stream: m_axis_tdata carries the visible machine
// state after that instruction (pc, index, Vx, VF, timers, stack level,
// status). font_base is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while idle, the block itself does not enforce this.
// Timing: one item at a time. After accept a plain instruction passes through
// the execute state, and its result is valid in the next cycle. BCD adds
// three digit writes before the result. Block store FX55 adds X+1 writes.
// Block load FX65 adds a read step and a write-back step per register, since
// the memory read is registered. After the result is taken the unit returns
// to idle with s_axis_tready high before it takes the next instruction.
// After reset the unit first sweeps the data memory to zero, one byte per
// cycle over all MEMORY_BYTES bytes; s_axis_tready stays low meanwhile.
// Reset: V0-VF, index, timers and stack pointer cleared, pc = 0x200,
// font_base = 80. The result is driven from the machine registers, which do
// not change while it waits; while the receiver stalls it holds and no new
// item is taken until it is delivered.
module chip8_execute_unit_top #(
  parameter int MEMORY_BYTES = 4096,
  parameter int STACK_DEPTH  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] instruction, [23:16] random_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [11:0] next_pc, [27:12] index_value,
                                      // [35:28] target_value, [43:36] flag_value,
                                      // [51:44] delay_value, [59:52] sound_value,
                                      // [64:60] stack_level, [66:65] status, rest 0
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i
);

  localparam int AW  = $clog2(MEMORY_BYTES);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_BCD  = 3'd3;
  localparam logic [2:0] S_STR  = 3'd4;
  localparam logic [2:0] S_LDR  = 3'd5;
  localparam logic [2:0] S_LDW  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]   state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [11:0]  font_q;
  logic [7:0]   v_q [16];
  logic [11:0]  pc_q;
  logic [15:0]  idx_q;
  logic [11:0]  stk_q [STACK_DEPTH];
  logic [SPW-1:0] sp_q;
  logic [7:0]   dt_q, st_q;
  logic [15:0]  ins_q;
  logic [7:0]   rnd_q, vx_q, vy_q;
  logic [1:0]   status_q;
  logic [4:0]   k_q;
  logic [7:0]   bcd_q;

  // Shared memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  c8eu_ram #(.Width(8), .Depth(MEMORY_BYTES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  wire [3:0]  op  = ins_q[15:12];
  wire [3:0]  xi  = ins_q[11:8];
  wire [3:0]  nb  = ins_q[3:0];
  wire [7:0]  nn  = ins_q[7:0];
  wire [11:0] nnn = ins_q[11:0];

  wire [AW-1:0] addr_k = AW'(idx_q + 16'(k_q[3:0]));

  assign s_axis_tready = (state_q == S_IDLE);

  // Digit extraction: hundreds by compare-subtract, tens by multiply by 205 and shift, ones as the remainder
  logic [7:0]  bcd_digit, bcd_rem;
  logic [15:0] bcd_mul;
  always_comb begin
    bcd_digit = '0;
    bcd_rem   = bcd_q;
    bcd_mul   = {8'd0, bcd_q} * 16'd205;
    if (k_q == 5'd0) begin
      if (bcd_q >= 8'd200) begin bcd_digit = 8'd2; bcd_rem = bcd_q - 8'd200; end
      else if (bcd_q >= 8'd100) begin bcd_digit = 8'd1; bcd_rem = bcd_q - 8'd100; end
    end else if (k_q == 5'd1) begin
      bcd_digit = {3'd0, bcd_mul[15:11]};
      bcd_rem   = bcd_q - 8'(bcd_digit * 8'd10);
    end else begin
      bcd_digit = bcd_q;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_k;
    mem_wdata = '0;
    mem_raddr = addr_k;
    state_d   = state_q;
    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == AW'(MEMORY_BYTES - 1)) state_d = S_IDLE;
      end
      S_IDLE:  if (s_axis_tvalid) state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_OUT;
        if (op == c8eu_pkg::OP_MISC) begin
          case (nn)
            c8eu_pkg::FX_BCD: state_d = S_BCD;
            c8eu_pkg::FX_STR: state_d = S_STR;
            c8eu_pkg::FX_LDR: state_d = S_LDR;
            default: ;
          endcase
        end
      end
      S_BCD: begin
        mem_we    = 1'b1;
        mem_wdata = bcd_digit;
        if (k_q == 5'd2) state_d = S_OUT;
      end
      S_STR: begin
        mem_we    = 1'b1;
        mem_wdata = v_q[k_q[3:0]];
        if (k_q[3:0] == xi) state_d = S_OUT;
      end
      S_LDR: state_d = S_LDW;
      S_LDW: state_d = (k_q[3:0] == xi) ? S_OUT : S_LDR;
      S_OUT: if (m_axis_tready) state_d = S_IDLE;
      default: ;
    endcase
  end

  // Result word gathered from current state
  logic [71:0] res;
  always_comb begin
    res = '0;
    res[11:0]  = pc_q;
    res[27:12] = idx_q;
    res[35:28] = v_q[xi];
    res[43:36] = v_q[15];
    res[51:44] = dt_q;
    res[59:52] = st_q;
    res[64:60] = 5'(sp_q);
    res[66:65] = status_q;
  end

  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = res;

  logic [8:0] sum9;
  logic [8:0] dif9;
  assign sum9 = {1'b0, vx_q} + {1'b0, vy_q};
  assign dif9 = (nb == c8eu_pkg::ALU_SBN) ? ({1'b0, vy_q} - {1'b0, vx_q})
                                           : ({1'b0, vx_q} - {1'b0, vy_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      font_q   <= c8eu_pkg::FONT_RESET;
      for (int i = 0; i < 16; i++) v_q[i] <= '0;
      pc_q     <= c8eu_pkg::PC_RESET;
      idx_q    <= '0;
      sp_q     <= '0;
      dt_q     <= '0;
      st_q     <= '0;
      status_q <= c8eu_pkg::ST_OK;
      k_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) font_q <= cfg_wdata_i;
      case (state_q)
        S_CLR: clr_q <= clr_q + 1'b1;
        S_IDLE: if (s_axis_tvalid) begin
          ins_q    <= s_axis_tdata[15:0];
          rnd_q    <= s_axis_tdata[23:16];
          vx_q     <= v_q[s_axis_tdata[11:8]];
          vy_q     <= v_q[s_axis_tdata[7:4]];
          status_q <= c8eu_pkg::ST_OK;
          k_q      <= '0;
        end
        S_EXEC: begin
          case (op)
            c8eu_pkg::OP_SYS:
              if (ins_q == c8eu_pkg::INS_RET) begin
                if (sp_q == '0) status_q <= c8eu_pkg::ST_UNDERFLOW;
                else begin
                  sp_q <= sp_q - 1'b1;
                  pc_q <= stk_q[SIW'(sp_q - 1'b1)];
                end
              end else status_q <= c8eu_pkg::ST_UNSUP;
            c8eu_pkg::OP_JP: pc_q <= nnn;
            c8eu_pkg::OP_CALL:
              if (sp_q >= SPW'(STACK_DEPTH)) status_q <= c8eu_pkg::ST_OVERFLOW;
              else begin
                stk_q[SIW'(sp_q)] <= pc_q;
                sp_q <= sp_q + 1'b1;
                pc_q <= nnn;
              end
            c8eu_pkg::OP_SEB:  if (vx_q == nn) pc_q <= pc_q + 12'd2;
            c8eu_pkg::OP_SNEB: if (vx_q != nn) pc_q <= pc_q + 12'd2;
            c8eu_pkg::OP_SER:
              if (nb != 4'h0) status_q <= c8eu_pkg::ST_UNSUP;
              else if (vx_q == vy_q) pc_q <= pc_q + 12'd2;
            c8eu_pkg::OP_SNER:
              if (nb != 4'h0) status_q <= c8eu_pkg::ST_UNSUP;
              else if (vx_q != vy_q) pc_q <= pc_q + 12'd2;
            c8eu_pkg::OP_LDB:  v_q[xi] <= nn;
            c8eu_pkg::OP_ADDB: v_q[xi] <= vx_q + nn;
            c8eu_pkg::OP_ALU:
              case (nb)
                c8eu_pkg::ALU_LD:  v_q[xi] <= vy_q;
                c8eu_pkg::ALU_OR:  v_q[xi] <= vx_q | vy_q;
                c8eu_pkg::ALU_AND: v_q[xi] <= vx_q & vy_q;
                c8eu_pkg::ALU_XOR: v_q[xi] <= vx_q ^ vy_q;
                c8eu_pkg::ALU_ADD: begin
                  v_q[xi] <= sum9[7:0];
                  v_q[15] <= {7'd0, sum9[8]};
                end
                c8eu_pkg::ALU_SUB, c8eu_pkg::ALU_SBN: begin
                  v_q[xi] <= dif9[7:0];
                  v_q[15] <= {7'd0, ~dif9[8]};
                end
                c8eu_pkg::ALU_SHR: begin
                  v_q[xi] <= {1'b0, vx_q[7:1]};
                  v_q[15] <= {7'd0, vx_q[0]};
                end
                c8eu_pkg::ALU_SHL: begin
                  v_q[xi] <= {vx_q[6:0], 1'b0};
                  v_q[15] <= {7'd0, vx_q[7]};
                end
                default: status_q <= c8eu_pkg::ST_UNSUP;
              endcase
            c8eu_pkg::OP_LDI:  idx_q <= {4'd0, nnn};
            c8eu_pkg::OP_JPV0: pc_q <= nnn + {4'd0, v_q[0]};
            c8eu_pkg::OP_RND:  v_q[xi] <= rnd_q & nn;
            c8eu_pkg::OP_MISC:
              case (nn)
                c8eu_pkg::FX_GDT: v_q[xi] <= dt_q;
                c8eu_pkg::FX_SDT: dt_q <= vx_q;
                c8eu_pkg::FX_SST: st_q <= vx_q;
                c8eu_pkg::FX_ADI: idx_q <= idx_q + {8'd0, vx_q};
                c8eu_pkg::FX_FNT:
                  idx_q <= {4'd0, font_q} + {10'd0, vx_q[3:0], 2'b00}
                           + {12'd0, vx_q[3:0]};
                c8eu_pkg::FX_BCD: bcd_q <= vx_q;
                c8eu_pkg::FX_STR: ;
                c8eu_pkg::FX_LDR: ;
                default: status_q <= c8eu_pkg::ST_UNSUP;
              endcase
            default: status_q <= c8eu_pkg::ST_UNSUP;
          endcase
        end
        S_BCD: begin
          bcd_q <= bcd_rem;
          k_q   <= k_q + 1'b1;
        end
        S_STR: k_q <= k_q + 1'b1;
        S_LDW: begin
          v_q[k_q[3:0]] <= mem_rdata;
          k_q <= k_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> state_q != S_IDLE)
    else $error("item finished without result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BCD) |-> k_q <= 5'd2)
    else $error("bcd step overrun");

endmodule

/* tb/sv/chip8_execute_unit_top_test.sv */
`timescale 1ns / 100ps

module chip8_execute_unit_top_test;

  localparam int MEM_BYTES   = 4096;
  localparam int STACK_DEPTH = 16;
  localparam int N_RANDOM    = 800;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  level;
    logic [7:0]  sound;
    logic [7:0]  delay;
    logic [7:0]  vf;
    logic [7:0]  vx;
    logic [15:0] index;
    logic [11:0] pc;
  } state_view_t;

  typedef struct {
    logic [15:0] ins;
    logic [7:0]  rnd;
    bit          typed;
    state_view_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [11:0] cfg_wdata_i = '0;

  chip8_execute_unit_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // machine copy
  logic [7:0]  regs_q [16];
  logic [11:0] pc_q;
  logic [15:0] index_q;
  logic [11:0] ret_stack_q [STACK_DEPTH];
  int          depth_q;
  logic [7:0]  mem_q [MEM_BYTES];
  logic [7:0]  delay_q, sound_q;
  logic [11:0] font_q;

  state_view_t expected_q[$];
  int          mismatches = 0;
  int          checked = 0;
  int          cycles = 0;
  bit          sends_done = 1'b0;
  int          n_calls = 0, n_errs = 0;

  function automatic state_view_t execute(logic [15:0] ins, logic [7:0] rnd);
    state_view_t r;
    logic [3:0]  op, x, y, n;
    logic [7:0]  nn, vx, vy;
    logic [11:0] nnn;
    logic [8:0]  sum;
    c8eu_pkg::status_e st;
    bit          skip;
    op = ins[15:12]; x = ins[11:8]; y = ins[7:4]; n = ins[3:0];
    nn = ins[7:0]; nnn = ins[11:0];
    vx = regs_q[x]; vy = regs_q[y];
    st = c8eu_pkg::ST_OK; skip = 1'b0;
    case (op)
      c8eu_pkg::OP_SYS: begin
        if (ins == c8eu_pkg::INS_RET) begin
          if (depth_q == 0) st = c8eu_pkg::ST_UNDERFLOW;
          else begin
            depth_q--;
            pc_q = ret_stack_q[depth_q];
          end
        end else st = c8eu_pkg::ST_UNSUP;
      end
      c8eu_pkg::OP_JP: pc_q = nnn;
      c8eu_pkg::OP_CALL: begin
        if (depth_q >= STACK_DEPTH) st = c8eu_pkg::ST_OVERFLOW;
        else begin
          ret_stack_q[depth_q] = pc_q;
          depth_q++;
          pc_q = nnn;
        end
      end
      c8eu_pkg::OP_SEB:  skip = (vx == nn);
      c8eu_pkg::OP_SNEB: skip = (vx != nn);
      c8eu_pkg::OP_SER:  if (n == 4'h0) skip = (vx == vy); else st = c8eu_pkg::ST_UNSUP;
      c8eu_pkg::OP_SNER: if (n == 4'h0) skip = (vx != vy); else st = c8eu_pkg::ST_UNSUP;
      c8eu_pkg::OP_LDB:  regs_q[x] = nn;
      c8eu_pkg::OP_ADDB: regs_q[x] = vx + nn;
      c8eu_pkg::OP_ALU: begin
        case (n)
          c8eu_pkg::ALU_LD:  regs_q[x] = vy;
          c8eu_pkg::ALU_OR:  regs_q[x] = vx | vy;
          c8eu_pkg::ALU_AND: regs_q[x] = vx & vy;
          c8eu_pkg::ALU_XOR: regs_q[x] = vx ^ vy;
          c8eu_pkg::ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            regs_q[x] = sum[7:0];
            regs_q[15] = {7'd0, sum[8]};
          end
          c8eu_pkg::ALU_SUB: begin
            regs_q[x] = vx - vy;
            regs_q[15] = {7'd0, vx >= vy};
          end
          c8eu_pkg::ALU_SBN: begin
            regs_q[x] = vy - vx;
            regs_q[15] = {7'd0, vy >= vx};
          end
          c8eu_pkg::ALU_SHR: begin
            regs_q[x] = vx >> 1;
            regs_q[15] = {7'd0, vx[0]};
          end
          c8eu_pkg::ALU_SHL: begin
            regs_q[x] = vx << 1;
            regs_q[15] = {7'd0, vx[7]};
          end
          default: st = c8eu_pkg::ST_UNSUP;
        endcase
      end
      c8eu_pkg::OP_LDI:  index_q = {4'd0, nnn};
      c8eu_pkg::OP_JPV0: pc_q = nnn + {4'd0, regs_q[0]};
      c8eu_pkg::OP_RND:  regs_q[x] = rnd & nn;
      c8eu_pkg::OP_MISC: begin
        case (nn)
          c8eu_pkg::FX_GDT: regs_q[x] = delay_q;
          c8eu_pkg::FX_SDT: delay_q = vx;
          c8eu_pkg::FX_SST: sound_q = vx;
          c8eu_pkg::FX_ADI: index_q = index_q + vx;
          c8eu_pkg::FX_FNT: index_q = {4'd0, font_q} + vx[3:0] * 16'd5;
          c8eu_pkg::FX_BCD: begin
            mem_q[(index_q + 0) % MEM_BYTES] = vx / 100;
            mem_q[(index_q + 1) % MEM_BYTES] = (vx / 10) % 10;
            mem_q[(index_q + 2) % MEM_BYTES] = vx % 10;
          end
          c8eu_pkg::FX_STR:
            for (int i = 0; i <= x; i++) mem_q[(index_q + i) % MEM_BYTES] = regs_q[i];
          c8eu_pkg::FX_LDR:
            for (int i = 0; i <= x; i++) regs_q[i] = mem_q[(index_q + i) % MEM_BYTES];
          default: st = c8eu_pkg::ST_UNSUP;
        endcase
      end
      default: st = c8eu_pkg::ST_UNSUP;
    endcase
    if (skip) pc_q = pc_q + 12'd2;
    r.pc = pc_q; r.index = index_q; r.vx = regs_q[x]; r.vf = regs_q[15];
    r.delay = delay_q; r.sound = sound_q; r.level = depth_q[4:0]; r.status = st;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("item %0d: %s got %0h want %0h", checked, what, got, want);
  endtask

  task automatic compare(state_view_t got, state_view_t want);
    if (got.pc !== want.pc)         report("next_pc", got.pc, want.pc);
    if (got.index !== want.index)   report("index_value", got.index, want.index);
    if (got.vx !== want.vx)         report("target_value", got.vx, want.vx);
    if (got.vf !== want.vf)         report("flag_value", got.vf, want.vf);
    if (got.delay !== want.delay)   report("delay_value", got.delay, want.delay);
    if (got.sound !== want.sound)   report("sound_value", got.sound, want.sound);
    if (got.level !== want.level)   report("stack_level", got.level, want.level);
    if (got.status !== want.status) report("status", got.status, want.status);
  endtask

  // result side: random stalls, check every accepted result
  initial begin
    int stall;
    @(posedge rst_ni);
    m_axis_tready <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      if (expected_q.size() == 0) report("unexpected result", 0, 0);
      else compare(m_axis_tdata[66:0], expected_q.pop_front());
      checked++;
      if (m_axis_tdata[71:67] !== 5'd0) report("pad bits", m_axis_tdata[71:67], 0);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send(logic [15:0] ins, logic [7:0] rnd, bit typed, state_view_t want);
    state_view_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rnd, ins};
    do @(posedge clk_i); while (!s_axis_tready);
    p = execute(ins, rnd);
    if (p.status != c8eu_pkg::ST_OK) n_errs++;
    if (ins[15:12] == c8eu_pkg::OP_CALL) n_calls++;
    expected_q.push_back(typed ? want : p);
  endtask

  task automatic drain_and_write_font(logic [11:0] base);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    font_q = base;
  endtask

  // random instruction, biased to executable ones; memory stays defined
  function automatic logic [15:0] pick_ins();
    logic [15:0] w;
    logic [7:0]  fx [8] = '{c8eu_pkg::FX_GDT, c8eu_pkg::FX_SDT, c8eu_pkg::FX_SST,
                            c8eu_pkg::FX_ADI, c8eu_pkg::FX_FNT, c8eu_pkg::FX_BCD,
                            c8eu_pkg::FX_STR, c8eu_pkg::FX_LDR};
    logic [3:0]  alu [9] = '{c8eu_pkg::ALU_LD, c8eu_pkg::ALU_OR, c8eu_pkg::ALU_AND,
                             c8eu_pkg::ALU_XOR, c8eu_pkg::ALU_ADD, c8eu_pkg::ALU_SUB,
                             c8eu_pkg::ALU_SHR, c8eu_pkg::ALU_SBN, c8eu_pkg::ALU_SHL};
    w = $urandom();
    case ($urandom_range(0, 11))
      0: w[15:12] = c8eu_pkg::OP_ALU;
      1: begin w[15:12] = c8eu_pkg::OP_ALU; w[3:0] = alu[$urandom_range(0, 8)]; end
      2: begin w[15:12] = c8eu_pkg::OP_ALU; w[3:0] = alu[$urandom_range(0, 8)]; end
      3: begin w[15:12] = c8eu_pkg::OP_MISC; w[7:0] = fx[$urandom_range(0, 7)]; end
      4: begin w[15:12] = c8eu_pkg::OP_MISC; w[7:0] = fx[$urandom_range(0, 7)]; end
      5: w[15:12] = $urandom_range(0, 1) ? c8eu_pkg::OP_CALL : c8eu_pkg::OP_SYS;
      6: w = c8eu_pkg::INS_RET;
      7: w[15:12] = $urandom_range(0, 1) ? c8eu_pkg::OP_LDB : c8eu_pkg::OP_ADDB;
      8: begin w[15:12] = $urandom_range(0, 1) ? c8eu_pkg::OP_SER : c8eu_pkg::OP_SNER;
           if ($urandom_range(0, 2) != 0) w[3:0] = 4'h0; end
      default: ;
    endcase
    return w;
  endfunction

  stim_row_t rows [$];

  initial begin
    state_view_t z;
    stim_row_t r;
    logic [11:0] bases [4];
    bases[0] = 12'h000; bases[1] = 12'hFFF; bases[2] = 12'h7A5; bases[3] = 12'h123;
    z = '0; z.pc = c8eu_pkg::PC_RESET;
    for (int i = 0; i < 16; i++) regs_q[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) mem_q[i] = '0;
    for (int i = 0; i < STACK_DEPTH; i++) ret_stack_q[i] = '0;
    pc_q = c8eu_pkg::PC_RESET; index_q = '0; depth_q = 0; delay_q = '0; sound_q = '0;
    font_q = c8eu_pkg::FONT_RESET;

    // underflow and unsupported right after reset, then mixed checked rows
    r.rnd = 8'h00; r.typed = 1;
    r.ins = c8eu_pkg::INS_RET; r.want = z; r.want.status = c8eu_pkg::ST_UNDERFLOW;
    rows.push_back(r);
    r.ins = 16'hE09E; r.want = z; r.want.status = c8eu_pkg::ST_UNSUP; rows.push_back(r);
    r.ins = 16'hFFFF; r.want = z; r.want.status = c8eu_pkg::ST_UNSUP; r.want.vx = 8'h00;
    rows.push_back(r);
    r.ins = 16'hD123; r.want = z; r.want.status = c8eu_pkg::ST_UNSUP; rows.push_back(r);
    r.typed = 0;
    r.ins = 16'h60FF; rows.push_back(r);
    r.ins = 16'h61FF; rows.push_back(r);
    r.ins = 16'h8014; rows.push_back(r);
    r.ins = 16'h8015; rows.push_back(r);
    r.ins = 16'h8017; rows.push_back(r);
    r.ins = 16'h81FE; rows.push_back(r);
    r.ins = 16'h8106; rows.push_back(r);
    r.ins = 16'h8F1E; rows.push_back(r);
    r.ins = 16'h8128; rows.push_back(r);
    r.ins = 16'h5011; rows.push_back(r);
    r.ins = 16'h3000; rows.push_back(r);
    r.ins = 16'h9010; rows.push_back(r);
    r.ins = 16'hCAFF; r.rnd = 8'hFF; rows.push_back(r);
    r.ins = 16'hC2AA; r.rnd = 8'h5F; rows.push_back(r);
    r.ins = 16'hAFFF; rows.push_back(r);
    r.ins = 16'hF133; rows.push_back(r);
    r.ins = 16'hFF55; rows.push_back(r);
    r.ins = 16'hFF65; rows.push_back(r);
    r.ins = 16'hFA1E; rows.push_back(r);
    r.ins = 16'hF129; rows.push_back(r);
    r.ins = 16'hBFFF; rows.push_back(r);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send(rows[i].ins, rows[i].rnd, rows[i].typed, rows[i].want);

    // fill the stack past its depth to reach overflow
    for (int i = 0; i <= STACK_DEPTH; i++)
      send({c8eu_pkg::OP_CALL, 12'($urandom())}, 8'h00, 0, z);
    for (int i = 0; i < 4; i++)
      send({c8eu_pkg::OP_MISC, 4'($urandom()), c8eu_pkg::FX_SDT}, 8'h00, 0, z);
    send({c8eu_pkg::OP_MISC, 4'h3, c8eu_pkg::FX_SST}, 8'h00, 0, z);
    send({c8eu_pkg::OP_MISC, 4'h4, c8eu_pkg::FX_GDT}, 8'h00, 0, z);

    for (int phase = 0; phase < 4; phase++) begin
      drain_and_write_font(bases[phase]);
      for (int i = 0; i < N_RANDOM / 4; i++) send(pick_ins(), 8'($urandom()), 0, z);
    end
    s_axis_tvalid <= 1'b0;
    sends_done = 1'b1;
  end

  initial begin
    while (!(sends_done && expected_q.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
    end else begin
      repeat (50) @(posedge clk_i);
      $display("Ran %0d instructions (%0d calls, %0d error statuses), 5 font bases.",
               checked, n_calls, n_errs);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/c8eu_pkg.sv
hdl/c8eu_ram.sv
hdl/chip8_execute_unit_top.sv
tb/sv/chip8_execute_unit_top_test.sv
